FILE: rtl/core/ata_pio_pkg.sv
// ----------------------------------------------------------------------------
// ata_pio_pkg
// Shared types and constants for the ATA PIO host sequencer.
// ----------------------------------------------------------------------------
package ata_pio_pkg;

  localparam int SECTOR_WORDS_DEF = 256;
  localparam int IDENT_WORDS      = 256;
  localparam int MAX_RES          = 8;
  localparam int RES_CNT_W        = 4;

  localparam logic [28:0] POLL_LIMIT_RST = 29'h1000_0000;
  localparam logic [7:0]  RST_TIMEOUT_RST = 8'd100;

  // configuration register indexes
  localparam logic CFG_POLL_LIMIT  = 1'b0;
  localparam logic CFG_RST_TIMEOUT = 1'b1;

  // command codes
  localparam logic [2:0] CMD_PROBE   = 3'd0;
  localparam logic [2:0] CMD_RD_SECT = 3'd1;
  localparam logic [2:0] CMD_WR_SECT = 3'd2;
  localparam logic [2:0] CMD_RESP    = 3'd3;
  localparam logic [2:0] CMD_WDATA   = 3'd4;
  localparam logic [2:0] CMD_TICK    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_RD   = 2'd0;
  localparam logic [1:0] KIND_WR   = 2'd1;
  localparam logic [1:0] KIND_WORD = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  // done status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NODRIVE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_DEVERR  = 2'd3;

  // task file offsets
  localparam logic [2:0] REG_PIO_DATA = 3'd0;
  localparam logic [2:0] REG_COUNT    = 3'd2;
  localparam logic [2:0] REG_LBA0     = 3'd3;
  localparam logic [2:0] REG_LBA1     = 3'd4;
  localparam logic [2:0] REG_LBA2     = 3'd5;
  localparam logic [2:0] REG_HEAD     = 3'd6;
  localparam logic [2:0] REG_CMD_STAT = 3'd7;

  localparam logic [7:0] BSY  = 8'h80;
  localparam logic [7:0] DRQ  = 8'h08;
  localparam logic [7:0] ERRB = 8'h01;

  typedef enum logic [20:0] {
    PH_IDLE       = 21'd1 << 0,
    PH_RST_DELAY  = 21'd1 << 1,
    PH_RST_WAIT   = 21'd1 << 2,
    PH_SEL_DELAY  = 21'd1 << 3,
    PH_SEL_STATUS = 21'd1 << 4,
    PH_ID_DELAY   = 21'd1 << 5,
    PH_ID_STATUS  = 21'd1 << 6,
    PH_ID_BSY     = 21'd1 << 7,
    PH_ID_MID     = 21'd1 << 8,
    PH_ID_HI      = 21'd1 << 9,
    PH_ID_DRQ     = 21'd1 << 10,
    PH_ID_DRAIN   = 21'd1 << 11,
    PH_X_BSY1     = 21'd1 << 12,
    PH_X_DELAY    = 21'd1 << 13,
    PH_X_BSY2     = 21'd1 << 14,
    PH_X_DRQ      = 21'd1 << 15,
    PH_R_DATA     = 21'd1 << 16,
    PH_W_DATA     = 21'd1 << 17,
    PH_W_BSY3     = 21'd1 << 18,
    PH_W_ERR      = 21'd1 << 19,
    PH_W_FLUSH    = 21'd1 << 20
  } phase_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [27:0] lba;
    logic [15:0] data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        to_control_block;
    logic        channel;
    logic [2:0]  reg_offset;
    logic [15:0] value;
    logic [1:0]  status_code;
    logic        last;
  } out_word_t;

endpackage

FILE: rtl/core/ata_pio_host_sequencer_core.sv
// ----------------------------------------------------------------------------
// ata_pio_host_sequencer_core
// Host-side ATA PIO sequencer: probe, LBA28 single-sector read and write.
// ----------------------------------------------------------------------------
// Usage: the input channel takes command words (probe, read, write, bus read
// response, write data word, tick). Each accepted word is decoded against the
// protocol state and its results (0 to 7 words: bus accesses, sector words,
// done status) are loaded into a result buffer. The buffer drains one word
// per cycle on the output channel while the receiver does not stall, the last
// one flagged. The first result is registered and appears in the cycle after
// acceptance. The next input word is taken in the cycle the final buffered
// word leaves, so a word is not taken before the last one's results are out.
// Words causing no result pass at one per cycle. While the receiver stalls,
// the buffered word holds and input is stalled once the buffer is busy.
// Reset clears the protocol state to idle, drops buffered results and loads
// poll_limit 0x10000000 and reset_timeout_ticks 100.
// ----------------------------------------------------------------------------
module ata_pio_host_sequencer_core #(
  parameter int SECTOR_WORDS = ata_pio_pkg::SECTOR_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ata_pio_pkg::in_word_t   in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ata_pio_pkg::out_word_t  out_data,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [28:0]             cfg_data
);

  logic [28:0] poll_limit;
  logic [7:0]  reset_timeout_ticks;
  ata_pio_pkg::out_word_t res [ata_pio_pkg::MAX_RES];
  logic [ata_pio_pkg::RES_CNT_W-1:0] res_cnt;
  ata_pio_pkg::out_word_t buf_q [ata_pio_pkg::MAX_RES];
  logic [ata_pio_pkg::RES_CNT_W-1:0] buf_cnt;
  logic [2:0]  rd_ptr;
  logic        step;
  logic        drain_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= ata_pio_pkg::POLL_LIMIT_RST;
      reset_timeout_ticks <= ata_pio_pkg::RST_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ata_pio_pkg::CFG_POLL_LIMIT:  poll_limit <= cfg_data;
        ata_pio_pkg::CFG_RST_TIMEOUT: reset_timeout_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // accept when buffer empty or its final word leaves now
  assign drain_last = (buf_cnt != '0) && !out_stall
                      && ({1'b0, rd_ptr} == buf_cnt - 4'd1);
  assign in_stall = (buf_cnt != '0) && !drain_last;
  assign step = in_valid && !in_stall;

  ata_pio_seq #(.SECTOR_WORDS(SECTOR_WORDS)) u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .in_word             (in_data),
    .poll_limit          (poll_limit),
    .reset_timeout_ticks (reset_timeout_ticks),
    .res                 (res),
    .res_cnt             (res_cnt)
  );

  // result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
      rd_ptr <= '0;
    end else if (step) begin
      buf_cnt <= res_cnt;
      rd_ptr <= '0;
    end else if (drain_last) begin
      buf_cnt <= '0;
      rd_ptr <= '0;
    end else if (buf_cnt != '0 && !out_stall) begin
      rd_ptr <= rd_ptr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) buf_q <= res;
  end

  assign out_valid = (buf_cnt != '0);
  assign out_data = buf_q[rd_ptr];

endmodule

FILE: rtl/core/ata_pio_seq.sv
// ----------------------------------------------------------------------------
// ata_pio_seq
// Protocol state and next-state logic; builds the burst of result words
// that one input word causes.
// ----------------------------------------------------------------------------
module ata_pio_seq #(
  parameter int SECTOR_WORDS = ata_pio_pkg::SECTOR_WORDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  ata_pio_pkg::in_word_t                in_word,
  input  logic [28:0]                          poll_limit,
  input  logic [7:0]                           reset_timeout_ticks,
  output ata_pio_pkg::out_word_t               res [ata_pio_pkg::MAX_RES],
  output logic [ata_pio_pkg::RES_CNT_W-1:0]    res_cnt
);

  localparam int WC_W = $clog2(SECTOR_WORDS + 1) > 9 ? $clog2(SECTOR_WORDS + 1) : 9;

  ata_pio_pkg::phase_t phase, phase_next;
  logic        op_write, op_write_next;
  logic [1:0]  slot_index, slot_index_next;
  logic        drive_present, drive_present_next;
  logic        chosen_channel, chosen_channel_next;
  logic        chosen_slave, chosen_slave_next;
  logic [27:0] saved_sector_address, saved_sector_address_next;
  logic [WC_W-1:0] word_count, word_count_next;
  logic [28:0] poll_count, poll_count_next;
  logic [7:0]  elapsed_ticks, elapsed_ticks_next;
  logic [1:0]  delay_count, delay_count_next;
  logic [7:0]  saved_signature_mid, saved_signature_mid_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ata_pio_pkg::PH_IDLE;
      op_write <= 1'b0;
      slot_index <= '0;
      drive_present <= 1'b0;
      chosen_channel <= 1'b0;
      chosen_slave <= 1'b0;
      saved_sector_address <= '0;
      word_count <= '0;
      poll_count <= '0;
      elapsed_ticks <= '0;
      delay_count <= '0;
      saved_signature_mid <= '0;
    end else if (step) begin
      phase <= phase_next;
      op_write <= op_write_next;
      slot_index <= slot_index_next;
      drive_present <= drive_present_next;
      chosen_channel <= chosen_channel_next;
      chosen_slave <= chosen_slave_next;
      saved_sector_address <= saved_sector_address_next;
      word_count <= word_count_next;
      poll_count <= poll_count_next;
      elapsed_ticks <= elapsed_ticks_next;
      delay_count <= delay_count_next;
      saved_signature_mid <= saved_signature_mid_next;
    end
  end

  // next state and result burst
  always_comb begin
    logic [7:0]  s;
    logic [28:0] lim;
    logic [28:0] pc_inc;
    logic        expired;
    logic        chan;
    logic [3:0]  n;
    logic        do_fail;
    phase_next = phase;
    op_write_next = op_write;
    slot_index_next = slot_index;
    drive_present_next = drive_present;
    chosen_channel_next = chosen_channel;
    chosen_slave_next = chosen_slave;
    saved_sector_address_next = saved_sector_address;
    word_count_next = word_count;
    poll_count_next = poll_count;
    elapsed_ticks_next = elapsed_ticks;
    delay_count_next = delay_count;
    saved_signature_mid_next = saved_signature_mid;
    for (int i = 0; i < ata_pio_pkg::MAX_RES; i++) res[i] = '0;
    n = '0;
    do_fail = 1'b0;
    s = in_word.data[7:0];
    lim = (poll_limit == '0) ? 29'd1 : poll_limit;
    pc_inc = poll_count + 29'd1;
    expired = pc_inc >= lim;
    chan = (phase == ata_pio_pkg::PH_IDLE) ? 1'b0 : chosen_channel;
    case (phase)
      ata_pio_pkg::PH_RST_DELAY, ata_pio_pkg::PH_RST_WAIT, ata_pio_pkg::PH_SEL_DELAY,
      ata_pio_pkg::PH_SEL_STATUS, ata_pio_pkg::PH_ID_DELAY, ata_pio_pkg::PH_ID_STATUS,
      ata_pio_pkg::PH_ID_BSY, ata_pio_pkg::PH_ID_MID, ata_pio_pkg::PH_ID_HI,
      ata_pio_pkg::PH_ID_DRQ, ata_pio_pkg::PH_ID_DRAIN: chan = slot_index[1];
      default: chan = chosen_channel;
    endcase

    case (in_word.command)
      ata_pio_pkg::CMD_PROBE: begin
        if (phase == ata_pio_pkg::PH_IDLE) begin
          drive_present_next = 1'b0;
          slot_index_next = '0;
          do_fail = 1'b0;
          // soft reset of slot 0; the two control writes leave while still idle,
          // so they go out on the last chosen channel
          res[0] = '{ata_pio_pkg::KIND_WR, 1'b1, chosen_channel, 3'd0, 16'h0004, 2'd0, 1'b0};
          res[1] = '{ata_pio_pkg::KIND_WR, 1'b1, chosen_channel, 3'd0, 16'h0000, 2'd0, 1'b0};
          res[2] = '{ata_pio_pkg::KIND_RD, 1'b1, 1'b0, 3'd0, 16'h0000, 2'd0, 1'b0};
          n = 4'd3;
          delay_count_next = '0;
          phase_next = ata_pio_pkg::PH_RST_DELAY;
        end
      end
      ata_pio_pkg::CMD_RD_SECT, ata_pio_pkg::CMD_WR_SECT: begin
        if (phase == ata_pio_pkg::PH_IDLE) begin
          if (!drive_present) begin
            res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_NODRIVE, 1'b0};
            n = 4'd1;
          end else begin
            op_write_next = (in_word.command == ata_pio_pkg::CMD_WR_SECT);
            saved_sector_address_next = in_word.lba;
            poll_count_next = '0;
            phase_next = ata_pio_pkg::PH_X_BSY1;
            res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chosen_channel, ata_pio_pkg::REG_CMD_STAT,
                       16'h0, 2'd0, 1'b0};
            n = 4'd1;
          end
        end
      end
      ata_pio_pkg::CMD_RESP: begin
        case (phase)
          ata_pio_pkg::PH_RST_DELAY, ata_pio_pkg::PH_SEL_DELAY,
          ata_pio_pkg::PH_ID_DELAY, ata_pio_pkg::PH_X_DELAY: begin
            if (delay_count != 2'd3) begin
              delay_count_next = delay_count + 2'd1;
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b1, chan, 3'd0, 16'h0, 2'd0, 1'b0};
              n = 4'd1;
            end else begin
              case (phase)
                ata_pio_pkg::PH_RST_DELAY: begin
                  elapsed_ticks_next = '0;
                  phase_next = ata_pio_pkg::PH_RST_WAIT;
                  res[0] = '{ata_pio_pkg::KIND_RD, 1'b1, chan, 3'd0, 16'h0, 2'd0, 1'b0};
                end
                ata_pio_pkg::PH_X_DELAY: begin
                  poll_count_next = '0;
                  phase_next = ata_pio_pkg::PH_X_BSY2;
                  res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                             16'h0, 2'd0, 1'b0};
                end
                ata_pio_pkg::PH_SEL_DELAY: begin
                  phase_next = ata_pio_pkg::PH_SEL_STATUS;
                  res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                             16'h0, 2'd0, 1'b0};
                end
                default: begin
                  phase_next = ata_pio_pkg::PH_ID_STATUS;
                  res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                             16'h0, 2'd0, 1'b0};
                end
              endcase
              n = 4'd1;
            end
          end
          ata_pio_pkg::PH_RST_WAIT: begin
            if ((s & ata_pio_pkg::BSY) == '0) begin
              res[0] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_HEAD,
                         {8'h00, 3'b101, slot_index[0], 4'h0}, 2'd0, 1'b0};
              res[1] = '{ata_pio_pkg::KIND_RD, 1'b1, chan, 3'd0, 16'h0, 2'd0, 1'b0};
              n = 4'd2;
              delay_count_next = '0;
              phase_next = ata_pio_pkg::PH_SEL_DELAY;
            end else if (s == 8'hFF || elapsed_ticks >= reset_timeout_ticks) begin
              do_fail = 1'b1;
            end else begin
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b1, chan, 3'd0, 16'h0, 2'd0, 1'b0};
              n = 4'd1;
            end
          end
          ata_pio_pkg::PH_SEL_STATUS: begin
            if (s == 8'hFF) begin
              do_fail = 1'b1;
            end else begin
              res[0] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_COUNT, 16'h0, 2'd0, 1'b0};
              res[1] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_LBA0, 16'h0, 2'd0, 1'b0};
              res[2] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_LBA1, 16'h0, 2'd0, 1'b0};
              res[3] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_LBA2, 16'h0, 2'd0, 1'b0};
              res[4] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                         16'h00EC, 2'd0, 1'b0};
              res[5] = '{ata_pio_pkg::KIND_RD, 1'b1, chan, 3'd0, 16'h0, 2'd0, 1'b0};
              n = 4'd6;
              delay_count_next = '0;
              phase_next = ata_pio_pkg::PH_ID_DELAY;
            end
          end
          ata_pio_pkg::PH_ID_STATUS: begin
            if (s == 8'h00) begin
              do_fail = 1'b1;
            end else begin
              poll_count_next = '0;
              phase_next = ata_pio_pkg::PH_ID_BSY;
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                         16'h0, 2'd0, 1'b0};
              n = 4'd1;
            end
          end
          ata_pio_pkg::PH_ID_BSY: begin
            if ((s & ata_pio_pkg::BSY) == '0) begin
              phase_next = ata_pio_pkg::PH_ID_MID;
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_LBA1, 16'h0, 2'd0, 1'b0};
              n = 4'd1;
            end else begin
              poll_count_next = pc_inc;
              if (expired) begin
                do_fail = 1'b1;
              end else begin
                res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                           16'h0, 2'd0, 1'b0};
                n = 4'd1;
              end
            end
          end
          ata_pio_pkg::PH_ID_MID: begin
            saved_signature_mid_next = s;
            phase_next = ata_pio_pkg::PH_ID_HI;
            res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_LBA2, 16'h0, 2'd0, 1'b0};
            n = 4'd1;
          end
          ata_pio_pkg::PH_ID_HI: begin
            if (saved_signature_mid == 8'h14 && s == 8'hEB) begin
              do_fail = 1'b1;
            end else begin
              poll_count_next = '0;
              phase_next = ata_pio_pkg::PH_ID_DRQ;
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                         16'h0, 2'd0, 1'b0};
              n = 4'd1;
            end
          end
          ata_pio_pkg::PH_ID_DRQ: begin
            if ((s & ata_pio_pkg::ERRB) != '0) begin
              do_fail = 1'b1;
            end else if ((s & ata_pio_pkg::DRQ) != '0) begin
              word_count_next = '0;
              phase_next = ata_pio_pkg::PH_ID_DRAIN;
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_PIO_DATA,
                         16'h0, 2'd0, 1'b0};
              n = 4'd1;
            end else begin
              poll_count_next = pc_inc;
              if (expired) begin
                do_fail = 1'b1;
              end else begin
                res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                           16'h0, 2'd0, 1'b0};
                n = 4'd1;
              end
            end
          end
          ata_pio_pkg::PH_ID_DRAIN: begin
            word_count_next = word_count + 1'b1;
            if (word_count_next >= WC_W'(ata_pio_pkg::IDENT_WORDS)) begin
              drive_present_next = 1'b1;
              chosen_channel_next = slot_index[1];
              chosen_slave_next = slot_index[0];
              phase_next = ata_pio_pkg::PH_IDLE;
              res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_OK, 1'b0};
            end else begin
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_PIO_DATA,
                         16'h0, 2'd0, 1'b0};
            end
            n = 4'd1;
          end
          ata_pio_pkg::PH_X_BSY1, ata_pio_pkg::PH_X_BSY2, ata_pio_pkg::PH_W_BSY3: begin
            if ((s & ata_pio_pkg::BSY) == '0) begin
              if (phase == ata_pio_pkg::PH_X_BSY1) begin
                // task file for one sector
                res[0] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_HEAD,
                           {8'h00, 3'b111, chosen_slave, saved_sector_address[27:24]},
                           2'd0, 1'b0};
                res[1] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_COUNT, 16'h1, 2'd0, 1'b0};
                res[2] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_LBA0,
                           {8'h00, saved_sector_address[7:0]}, 2'd0, 1'b0};
                res[3] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_LBA1,
                           {8'h00, saved_sector_address[15:8]}, 2'd0, 1'b0};
                res[4] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_LBA2,
                           {8'h00, saved_sector_address[23:16]}, 2'd0, 1'b0};
                res[5] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                           op_write ? 16'h0030 : 16'h0020, 2'd0, 1'b0};
                res[6] = '{ata_pio_pkg::KIND_RD, 1'b1, chan, 3'd0, 16'h0, 2'd0, 1'b0};
                n = 4'd7;
                delay_count_next = '0;
                phase_next = ata_pio_pkg::PH_X_DELAY;
              end else begin
                if (phase == ata_pio_pkg::PH_X_BSY2) begin
                  poll_count_next = '0;
                  phase_next = ata_pio_pkg::PH_X_DRQ;
                end else begin
                  phase_next = ata_pio_pkg::PH_W_ERR;
                end
                res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                           16'h0, 2'd0, 1'b0};
                n = 4'd1;
              end
            end else begin
              poll_count_next = pc_inc;
              if (expired) begin
                phase_next = ata_pio_pkg::PH_IDLE;
                res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_TIMEOUT, 1'b0};
              end else begin
                res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                           16'h0, 2'd0, 1'b0};
              end
              n = 4'd1;
            end
          end
          ata_pio_pkg::PH_X_DRQ: begin
            if ((s & ata_pio_pkg::ERRB) != '0) begin
              phase_next = ata_pio_pkg::PH_IDLE;
              res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_DEVERR, 1'b0};
              n = 4'd1;
            end else if ((s & ata_pio_pkg::DRQ) != '0) begin
              word_count_next = '0;
              if (op_write) begin
                phase_next = ata_pio_pkg::PH_W_DATA;
              end else begin
                phase_next = ata_pio_pkg::PH_R_DATA;
                res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_PIO_DATA,
                           16'h0, 2'd0, 1'b0};
                n = 4'd1;
              end
            end else begin
              poll_count_next = pc_inc;
              if (expired) begin
                phase_next = ata_pio_pkg::PH_IDLE;
                res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_TIMEOUT, 1'b0};
              end else begin
                res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                           16'h0, 2'd0, 1'b0};
              end
              n = 4'd1;
            end
          end
          ata_pio_pkg::PH_R_DATA: begin
            res[0] = '{ata_pio_pkg::KIND_WORD, 1'b0, 1'b0, 3'd0, in_word.data, 2'd0, 1'b0};
            word_count_next = word_count + 1'b1;
            if (word_count_next >= WC_W'(SECTOR_WORDS)) begin
              phase_next = ata_pio_pkg::PH_IDLE;
              res[1] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_OK, 1'b0};
            end else begin
              res[1] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_PIO_DATA,
                         16'h0, 2'd0, 1'b0};
            end
            n = 4'd2;
          end
          ata_pio_pkg::PH_W_ERR: begin
            if ((s & ata_pio_pkg::ERRB) != '0) begin
              phase_next = ata_pio_pkg::PH_IDLE;
              res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_DEVERR, 1'b0};
              n = 4'd1;
            end else begin
              res[0] = '{ata_pio_pkg::KIND_WR, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                         16'h00E7, 2'd0, 1'b0};
              res[1] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                         16'h0, 2'd0, 1'b0};
              n = 4'd2;
              poll_count_next = '0;
              phase_next = ata_pio_pkg::PH_W_FLUSH;
            end
          end
          ata_pio_pkg::PH_W_FLUSH: begin
            if ((s & ata_pio_pkg::BSY) != '0) poll_count_next = pc_inc;
            if ((s & ata_pio_pkg::BSY) == '0 || expired) begin
              phase_next = ata_pio_pkg::PH_IDLE;
              res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_OK, 1'b0};
            end else begin
              res[0] = '{ata_pio_pkg::KIND_RD, 1'b0, chan, ata_pio_pkg::REG_CMD_STAT,
                         16'h0, 2'd0, 1'b0};
            end
            n = 4'd1;
          end
          default: ;
        endcase
      end
      ata_pio_pkg::CMD_WDATA: begin
        if (phase == ata_pio_pkg::PH_W_DATA) begin
          res[0] = '{ata_pio_pkg::KIND_WR, 1'b0, chosen_channel, ata_pio_pkg::REG_PIO_DATA,
                     in_word.data, 2'd0, 1'b0};
          n = 4'd1;
          word_count_next = word_count + 1'b1;
          if (word_count_next >= WC_W'(SECTOR_WORDS)) begin
            poll_count_next = '0;
            phase_next = ata_pio_pkg::PH_W_BSY3;
            res[1] = '{ata_pio_pkg::KIND_RD, 1'b0, chosen_channel, ata_pio_pkg::REG_CMD_STAT,
                       16'h0, 2'd0, 1'b0};
            n = 4'd2;
          end
        end
      end
      ata_pio_pkg::CMD_TICK: begin
        if (phase == ata_pio_pkg::PH_RST_WAIT && elapsed_ticks != 8'hFF)
          elapsed_ticks_next = elapsed_ticks + 8'd1;
      end
      default: ;
    endcase

    // slot failure: next slot's soft reset, or no drive after the last slot
    if (do_fail) begin
      if (slot_index == 2'd3) begin
        phase_next = ata_pio_pkg::PH_IDLE;
        res[0] = '{ata_pio_pkg::KIND_DONE, 1'b0, 1'b0, 3'd0, 16'h0, ata_pio_pkg::ST_NODRIVE, 1'b0};
        n = 4'd1;
      end else begin
        slot_index_next = slot_index + 2'd1;
        res[0] = '{ata_pio_pkg::KIND_WR, 1'b1, slot_index_next[1], 3'd0, 16'h0004, 2'd0, 1'b0};
        res[1] = '{ata_pio_pkg::KIND_WR, 1'b1, slot_index_next[1], 3'd0, 16'h0000, 2'd0, 1'b0};
        res[2] = '{ata_pio_pkg::KIND_RD, 1'b1, slot_index_next[1], 3'd0, 16'h0000, 2'd0, 1'b0};
        n = 4'd3;
        delay_count_next = '0;
        phase_next = ata_pio_pkg::PH_RST_DELAY;
      end
    end

    // mark the final word of the burst
    for (int i = 0; i < ata_pio_pkg::MAX_RES; i++) begin
      if (n != '0 && 4'(i) == n - 4'd1) res[i].last = 1'b1;
    end
    res_cnt = n;
  end

endmodule
